/* rtl/quote_aware_tokenizer_unit_assert.svh */
// Assertion macros for the quote aware tokenizer.
// Taken in by the top level with `include; depends on nothing else.
`ifndef QUOTE_AWARE_TOKENIZER_UNIT_ASSERT_SVH
`define QUOTE_AWARE_TOKENIZER_UNIT_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define QAT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("qat assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qat assertion failed");

`endif

/* rtl/qat_pkg.sv */
// Shared constants, token type and byte classification for the tokenizer.
// Used by the token interface, the top level and the testbench; depends on nothing.
package qat_pkg;

	localparam int WORD_LIMIT  = 4096;
	localparam int OFFSET_BITS = 24;
	localparam int LEN_W       = 13;
	localparam int KIND_W      = 2;

	// Token kinds.
	localparam logic [KIND_W-1:0] KIND_WORD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELIM   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NEWLINE = 2'd2;

	// Bytes with a special role.
	localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
	localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;
	localparam logic [7:0] BYTE_SQUOTE    = 8'h27;
	localparam logic [7:0] BYTE_DQUOTE    = 8'h22;

	typedef logic [OFFSET_BITS-1:0] offset_t;
	typedef logic [LEN_W-1:0]       length_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		offset_t           start;
		length_t           length;
		logic              final_token;
	} token_t;

	// Whitespace and the delimiters that end a word outside quotes.
	function automatic logic is_separator(input logic [7:0] c);
		return c inside {8'h20, 8'h0A, 8'h09, 8'h0B, 8'h7B, 8'h7D, 8'h28, 8'h29,
			8'h3B, 8'h2C, 8'h3A, 8'h2F, 8'h3C, 8'h3E};
	endfunction

endpackage

/* rtl/qat_byte_if.sv */
// Channel that carries input bytes into the tokenizer.
// Depends on nothing.
interface qat_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/qat_token_if.sv */
// Channel that carries tokens out of the tokenizer.
// Depends on qat_pkg for field widths.
interface qat_token_if;
	logic                          valid;
	logic                          ready;
	logic [qat_pkg::KIND_W-1:0]    token_kind;
	logic [qat_pkg::OFFSET_BITS-1:0] token_start;
	logic [qat_pkg::LEN_W-1:0]     token_length;
	logic                          final_token;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output final_token, input ready);
	modport sink (input valid, input token_kind, input token_start,
		input token_length, input final_token, output ready);
endinterface

/* rtl/quote_aware_tokenizer_unit.sv */
// Top level of the tokenizer; depends on qat_pkg, qat_byte_if, qat_token_if and the macros.
// The tokens of a byte are registered in the token register once the byte moves on from the input register.
// Throughput: one byte per cycle while each byte yields at most one token and the receiver is ready; a
// byte that yields more tokens holds the three-entry token register until its last token is being taken.
// Reset (arst_n low, asynchronous) clears quote state, history, word count and offset,
// and empties the input and token registers.
`include "quote_aware_tokenizer_unit_assert.svh"

module quote_aware_tokenizer_unit (
	input logic clk,
	input logic arst_n,
	qat_byte_if.sink bytes,
	qat_token_if.source tokens
);

	// Input register.
	logic       byte_vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Tokenizer state.
	logic               dq_q;
	logic               sq_q;
	logic [7:0]         prior_q;
	logic [7:0]         prior2_q;
	qat_pkg::length_t   word_cnt_q;
	qat_pkg::offset_t   word_begin_q;
	qat_pkg::offset_t   pos_q;

	// Token register: up to three tokens from one byte, head at entry zero.
	qat_pkg::token_t tok_q [3];
	logic [1:0]      tok_cnt_q;

	logic tok_pop;
	logic buf_free;
	logic advance;

	assign tok_pop  = (tok_cnt_q != 2'd0) && tokens.ready;
	assign buf_free = (tok_cnt_q == 2'd0) || ((tok_cnt_q == 2'd1) && tok_pop);
	assign advance  = byte_vld_s1 && buf_free;
	assign bytes.ready = !byte_vld_s1 || buf_free;

	// Capture the incoming byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_vld_s1 <= 1'b0;
		end else if (bytes.ready) begin
			byte_vld_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.data_byte;
			last_s1 <= bytes.last_byte;
		end
	end

	// Classify the byte and decide on splitting and quote toggles.
	logic             split_sep;
	logic             full;
	logic             keep;
	logic             split;
	logic             dq_nxt;
	logic             sq_nxt;
	logic             word_vld;
	logic             delim_vld;
	logic             nl_vld;
	qat_pkg::token_t  word_tok;
	qat_pkg::token_t  delim_tok;
	qat_pkg::token_t  nl_tok;
	qat_pkg::token_t  new_tok [3];
	logic [1:0]       new_cnt;
	qat_pkg::offset_t pos_inc;

	assign pos_inc = pos_q + qat_pkg::offset_t'(1);

	always_comb begin
		split_sep = qat_pkg::is_separator(byte_s1) && !(dq_q || sq_q);
		dq_nxt = dq_q;
		sq_nxt = sq_q;
		if (!split_sep) begin
			if (byte_s1 == qat_pkg::BYTE_SQUOTE) begin
				if (!dq_q && !(prior_q == qat_pkg::BYTE_BACKSLASH &&
						prior2_q != qat_pkg::BYTE_BACKSLASH)) begin
					sq_nxt = !sq_q;
				end
			end else if (byte_s1 == qat_pkg::BYTE_DQUOTE) begin
				if (!sq_q && prior_q != qat_pkg::BYTE_BACKSLASH) begin
					dq_nxt = !dq_q;
				end
			end
		end
		full  = word_cnt_q == qat_pkg::LEN_W'(qat_pkg::WORD_LIMIT);
		keep  = !split_sep && !full;
		split = !keep;
	end

	// Build the tokens of this byte in order: word, one-byte token, appended newline.
	always_comb begin
		word_vld  = split ? (word_cnt_q != '0) : last_s1;
		delim_vld = split;
		nl_vld    = last_s1 && (byte_s1 != qat_pkg::BYTE_NEWLINE);

		word_tok.kind        = qat_pkg::KIND_WORD;
		word_tok.start       = (!split && word_cnt_q == '0) ? pos_q : word_begin_q;
		word_tok.length      = split ? word_cnt_q : word_cnt_q + qat_pkg::length_t'(1);
		word_tok.final_token = last_s1 && !nl_vld && !delim_vld;

		delim_tok.kind        = qat_pkg::KIND_DELIM;
		delim_tok.start       = pos_q;
		delim_tok.length      = qat_pkg::length_t'(1);
		delim_tok.final_token = last_s1 && !nl_vld;

		nl_tok.kind        = qat_pkg::KIND_NEWLINE;
		nl_tok.start       = pos_inc;
		nl_tok.length      = qat_pkg::length_t'(1);
		nl_tok.final_token = last_s1;

		// Pack the valid tokens toward entry zero.
		new_tok[0] = nl_tok;
		new_tok[1] = nl_tok;
		new_tok[2] = nl_tok;
		if (word_vld) begin
			new_tok[0] = word_tok;
			if (delim_vld) begin
				new_tok[1] = delim_tok;
			end
		end else if (delim_vld) begin
			new_tok[0] = delim_tok;
		end
		new_cnt = {1'b0, word_vld} + {1'b0, delim_vld} + {1'b0, nl_vld};
	end

	// Update the tokenizer state when the registered byte moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dq_q         <= 1'b0;
			sq_q         <= 1'b0;
			prior_q      <= '0;
			prior2_q     <= '0;
			word_cnt_q   <= '0;
			word_begin_q <= '0;
			pos_q        <= '0;
		end else if (advance) begin
			if (last_s1) begin
				dq_q         <= 1'b0;
				sq_q         <= 1'b0;
				prior_q      <= '0;
				prior2_q     <= '0;
				word_cnt_q   <= '0;
				word_begin_q <= '0;
				pos_q        <= '0;
			end else begin
				dq_q  <= dq_nxt;
				sq_q  <= sq_nxt;
				pos_q <= pos_inc;
				if (keep) begin
					word_cnt_q <= word_cnt_q + qat_pkg::length_t'(1);
					prior2_q   <= prior_q;
					prior_q    <= byte_s1;
					if (word_cnt_q == '0) begin
						word_begin_q <= pos_q;
					end
				end else begin
					word_cnt_q <= '0;
				end
			end
		end
	end

	// Token register: load a fresh group or shift out the head token.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_cnt_q <= 2'd0;
		end else if (advance) begin
			tok_cnt_q <= new_cnt;
		end else if (tok_pop) begin
			tok_cnt_q <= tok_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tok_q[0] <= new_tok[0];
			tok_q[1] <= new_tok[1];
			tok_q[2] <= new_tok[2];
		end else if (tok_pop) begin
			tok_q[0] <= tok_q[1];
			tok_q[1] <= tok_q[2];
		end
	end

	assign tokens.valid        = tok_cnt_q != 2'd0;
	assign tokens.token_kind   = tok_q[0].kind;
	assign tokens.token_start  = tok_q[0].start;
	assign tokens.token_length = tok_q[0].length;
	assign tokens.final_token  = tok_q[0].final_token;

	// The two quote states exclude each other.
	`QAT_ASSERT_ALWAYS(a_quotes_exclusive, clk, arst_n, !(dq_q && sq_q))
	// A word never grows past the limit.
	`QAT_ASSERT_ALWAYS(a_word_bounded, clk, arst_n,
		word_cnt_q <= qat_pkg::LEN_W'(qat_pkg::WORD_LIMIT))
	// The last byte of a buffer leaves the state at its reset values.
	`QAT_ASSERT_NEXT(a_buffer_end_clears, clk, arst_n, advance && last_s1,
		word_cnt_q == '0 && pos_q == '0 && !dq_q && !sq_q)

endmodule

/* verif/quote_aware_tokenizer_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for quote_aware_tokenizer_unit: a directed table, a backpressure
// stretch and random text. Depends on qat_pkg, qat_byte_if and qat_token_if, and on the
// top level itself.
module quote_aware_tokenizer_unit_tb;
	import qat_pkg::*;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_e;

	// One row of the directed table. Typed rows carry their expected tokens by hand.
	typedef struct packed {
		logic [7:0] b;
		logic       l;
		logic       typed;
		logic [1:0] n_exp;
		token_t     e0;
		token_t     e1;
	} stim_row_t;

	localparam token_t NO_TOKEN = '0;

	// Whitespace and delimiters: space, newline, tab, vertical tab, { } ( ) ; , : / < >.
	localparam logic [7:0] SPLIT_BYTES [14] = '{8'h20, 8'h0A, 8'h09, 8'h0B, 8'h7B, 8'h7D,
		8'h28, 8'h29, 8'h3B, 8'h2C, 8'h3A, 8'h2F, 8'h3C, 8'h3E};

	localparam stim_row_t DIRECTED [25] = '{
		'{8'h00, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
		'{8'hFF, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
		'{8'h20, 1'b0, 1'b1, 2'd2, '{KIND_WORD, 24'd0, 13'd2, 1'b0},
			'{KIND_DELIM, 24'd2, 13'd1, 1'b0}},
		'{8'h7B, 1'b0, 1'b1, 2'd1, '{KIND_DELIM, 24'd3, 13'd1, 1'b0}, NO_TOKEN},
		'{BYTE_DQUOTE, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
		'{8'h20, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
		'{8'h3B, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
		'{BYTE_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
		'{BYTE_DQUOTE, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
		'{BYTE_SQUOTE, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
		'{BYTE_DQUOTE, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
		'{8'h2C, 1'b0, 1'b1, 2'd2, '{KIND_WORD, 24'd4, 13'd7, 1'b0},
			'{KIND_DELIM, 24'd11, 13'd1, 1'b0}},
		'{BYTE_SQUOTE, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
		'{BYTE_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
		'{BYTE_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
		'{BYTE_SQUOTE, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
		'{BYTE_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
		'{BYTE_SQUOTE, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
		'{BYTE_DQUOTE, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
		'{BYTE_NEWLINE, 1'b1, 1'b1, 2'd1, '{KIND_WORD, 24'd12, 13'd8, 1'b1}, NO_TOKEN},
		'{8'h78, 1'b1, 1'b1, 2'd2, '{KIND_WORD, 24'd0, 13'd1, 1'b0},
			'{KIND_NEWLINE, 24'd1, 13'd1, 1'b1}},
		'{8'h29, 1'b1, 1'b1, 2'd2, '{KIND_DELIM, 24'd0, 13'd1, 1'b0},
			'{KIND_NEWLINE, 24'd1, 13'd1, 1'b1}},
		'{BYTE_NEWLINE, 1'b1, 1'b1, 2'd1, '{KIND_DELIM, 24'd0, 13'd1, 1'b1}, NO_TOKEN},
		'{8'h09, 1'b0, 1'b1, 2'd1, '{KIND_DELIM, 24'd0, 13'd1, 1'b0}, NO_TOKEN},
		'{8'h0B, 1'b1, 1'b1, 2'd2, '{KIND_DELIM, 24'd1, 13'd1, 1'b0},
			'{KIND_NEWLINE, 24'd2, 13'd1, 1'b1}}
	};

	logic clk;
	logic arst_n;

	qat_byte_if  byte_ch ();
	qat_token_if token_ch ();

	quote_aware_tokenizer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.tokens (token_ch)
	);

	// Tokenizer state as the predictor sees it.
	logic        q_double;
	logic        q_single;
	logic [7:0]  hist1;
	logic [7:0]  hist2;
	int unsigned run_bytes;
	offset_t     word_start;
	offset_t     byte_offset;

	token_t step_tokens[$];
	token_t pending_tokens[$];
	token_t want;
	int     error_count;
	bit     rx_hold_request;

	// Clock and the single reset pulse.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Fixed time limit on the whole run.
	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic bit is_split_byte(input logic [7:0] c);
		foreach (SPLIT_BYTES[i])
			if (SPLIT_BYTES[i] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void push_token(input logic [KIND_W-1:0] kind, input offset_t start,
		input int unsigned len);
		token_t t;
		t.kind = kind;
		t.start = start;
		t.length = length_t'(len);
		t.final_token = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void clear_state();
		q_double = 1'b0;
		q_single = 1'b0;
		hist1 = '0;
		hist2 = '0;
		run_bytes = 0;
		word_start = '0;
		byte_offset = '0;
	endfunction

	// Works out the tokens that one accepted byte releases and advances the state.
	function automatic void tokenize_byte(input logic [7:0] c, input logic l);
		logic quoted;
		logic split;
		quoted = q_double | q_single;
		split = 1'b0;
		step_tokens.delete();
		if (is_split_byte(c) && !quoted) begin
			split = 1'b1;
		end else if (c == BYTE_SQUOTE) begin
			if (!q_double && !(hist1 == BYTE_BACKSLASH && hist2 != BYTE_BACKSLASH))
				q_single = ~q_single;
		end else if (c == BYTE_DQUOTE) begin
			if (!q_single && hist1 != BYTE_BACKSLASH)
				q_double = ~q_double;
		end

		// Keep the byte in the word, unless the word is already full.
		if (!split) begin
			if (run_bytes < WORD_LIMIT) begin
				if (run_bytes == 0)
					word_start = byte_offset;
				run_bytes++;
				hist2 = hist1;
				hist1 = c;
			end else begin
				split = 1'b1;
			end
		end

		if (split) begin
			if (run_bytes != 0) begin
				push_token(KIND_WORD, word_start, run_bytes);
				run_bytes = 0;
			end
			push_token(KIND_DELIM, byte_offset, 1);
		end

		// End of buffer: flush the word, add a newline if missing, and start over.
		if (l) begin
			if (run_bytes != 0)
				push_token(KIND_WORD, word_start, run_bytes);
			if (c != BYTE_NEWLINE)
				push_token(KIND_NEWLINE, byte_offset + 1'b1, 1);
			step_tokens[step_tokens.size() - 1].final_token = 1'b1;
			clear_state();
		end else begin
			byte_offset = byte_offset + 1'b1;
		end
	endfunction

	// Text-like byte: separators, quotes, backslashes and lowercase letters are common, the rest is any value.
	function automatic logic [7:0] random_text_byte();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			return SPLIT_BYTES[$urandom_range(0, 13)];
		else if (pick < 38)
			return BYTE_DQUOTE;
		else if (pick < 45)
			return BYTE_SQUOTE;
		else if (pick < 53)
			return BYTE_BACKSLASH;
		else if (pick < 75)
			return 8'($urandom_range(8'h61, 8'h7A));
		return 8'($urandom_range(0, 255));
	endfunction

	// Offers one byte and waits for it to be taken; the prediction is queued unless the
	// caller supplies its own expectation.
	task automatic send_byte(input logic [7:0] b, input logic l, input bit keep_prediction);
		@(negedge clk);
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.last_byte <= l;
		do
			@(posedge clk);
		while (!byte_ch.ready);
		tokenize_byte(b, l);
		if (keep_prediction)
			foreach (step_tokens[i])
				pending_tokens.push_back(step_tokens[i]);
	endtask

	// Holds the sender off until every expected token has come, then idles before returning.
	task automatic drain_tokens();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void check_field(input string name, input longint unsigned exp_val,
		input longint unsigned act_val);
		if (exp_val != act_val) begin
			$display("%0t: token %s mismatch, expected %0d, got %0d", $time, name, exp_val,
				act_val);
			error_count++;
		end
	endfunction

	// Compare each accepted token with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && token_ch.valid && token_ch.ready) begin
			if (pending_tokens.size() == 0) begin
				$display("%0t: unexpected token, expected none, got kind %0d start %0d length %0d final %0b",
					$time, token_ch.token_kind, token_ch.token_start, token_ch.token_length,
					token_ch.final_token);
				error_count++;
			end else begin
				want = pending_tokens.pop_front();
				check_field("kind", want.kind, token_ch.token_kind);
				check_field("start", want.start, token_ch.token_start);
				check_field("length", want.length, token_ch.token_length);
				check_field("final", want.final_token, token_ch.final_token);
			end
		end
	end

	// Token receiver: switches between open, random and periodic stalls, and honors a long
	// hold-off once it is requested.
	initial begin : token_sink
		int unsigned mode_left;
		int unsigned hold_left;
		int unsigned phase;
		rx_mode_e    mode;
		bit          hold_seen;
		token_ch.ready = 1'b0;
		mode_left = 0;
		hold_left = 0;
		phase = 0;
		mode = RX_OPEN;
		hold_seen = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_request && !hold_seen) begin
				hold_left = 100;
				hold_seen = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				token_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_e'($urandom_range(0, 2));
					mode_left = $urandom_range(10, 60);
				end
				mode_left--;
				phase++;
				case (mode)
					RX_OPEN: begin
						token_ch.ready <= 1'b1;
					end
					RX_RANDOM: begin
						token_ch.ready <= ($urandom_range(0, 2) != 0);
					end
					default: begin
						token_ch.ready <= (phase % 5 > 1);
					end
				endcase
			end
		end
	end

	// Stimulus: directed table, backpressure, then random text in bursts.
	initial begin : stimulus
		int unsigned burst_left;
		int unsigned gap;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last_byte = 1'b0;
		rx_hold_request = 1'b0;
		error_count = 0;
		burst_left = 0;
		clear_state();
		@(posedge arst_n);

		foreach (DIRECTED[i]) begin
			send_byte(DIRECTED[i].b, DIRECTED[i].l, !DIRECTED[i].typed);
			if (DIRECTED[i].typed) begin
				pending_tokens.push_back(DIRECTED[i].e0);
				if (DIRECTED[i].n_exp == 2'd2)
					pending_tokens.push_back(DIRECTED[i].e1);
			end
		end
		drain_tokens();

		// Receiver holds off while the sender keeps offering, so the block backs up.
		rx_hold_request = 1'b1;
		for (int i = 0; i < 20; i++)
			send_byte(random_text_byte(), 1'b0, 1'b1);
		send_byte(random_text_byte(), 1'b1, 1'b1);
		drain_tokens();

		// Random text, sent in bursts with gaps between them.
		for (int i = 0; i < 50; i++) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				repeat (gap) begin
					@(negedge clk);
					byte_ch.valid <= 1'b0;
				end
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
			send_byte(random_text_byte(), ($urandom_range(0, 19) == 0), 1'b1);
		end
		send_byte(8'h2E, 1'b1, 1'b1);
		drain_tokens();

		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/qat_pkg.sv
rtl/qat_byte_if.sv
rtl/qat_token_if.sv
rtl/quote_aware_tokenizer_unit.sv
verif/quote_aware_tokenizer_unit_tb.sv
